[rtl/uvss_pkg.sv]
package uvss_pkg;

	// Default set size and fixed field widths
	localparam int DEF_CAPACITY = 64;
	localparam int VAL_W        = 32;
	localparam int FRAC_W       = 8;
	localparam int MEAN_W       = 40;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_FIND  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_STATS = 2'd3
	} cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

[rtl/uvss_ram.sv]
module uvss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/uvss_div.sv]
module uvss_div #(
	parameter int DIVIDEND_W = 46,
	parameter int DIVISOR_W  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/unique_value_set_statistics.sv]
// Flow, input beat to result valid: clear, stats and find on an empty set go straight to the response state;
// find and a rejected add first scan the stored entries (one entry RAM read per cycle).
// A stored add also waits for the bit-serial mean divider before its response.
// Throughput: one command at a time; the next beat is taken the cycle after its result
// enters the output register, and a result that cannot enter it holds the input off.
// Reset (arst_n low) empties the set and zeroes min, max, sum and mean; the RAM is not cleared.
module unique_value_set_statistics #(
	parameter int CAPACITY = uvss_pkg::DEF_CAPACITY,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         cmd,
	input  logic signed [uvss_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic                               found,
	output logic [CW-1:0]                      entry_count,
	output logic signed [uvss_pkg::VAL_W-1:0]  smallest,
	output logic signed [uvss_pkg::VAL_W-1:0]  largest,
	output logic signed [uvss_pkg::MEAN_W-1:0] mean_fixed
);

	localparam int VW    = uvss_pkg::VAL_W;
	localparam int MW    = uvss_pkg::MEAN_W;
	localparam int FW    = uvss_pkg::FRAC_W;
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SUM_W = VW + $clog2(CAPACITY);
	localparam int DVD_W = SUM_W + FW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_RESP
	} state_t;

	state_t                   state_q;
	uvss_pkg::cmd_t           cmd_q;
	logic signed [VW-1:0]     value_q;
	logic [CW-1:0]            count_q;
	logic signed [VW-1:0]     min_q;
	logic signed [VW-1:0]     max_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [MW-1:0]     mean_q;
	uvss_pkg::status_t        status_q;
	logic                     found_q;
	logic [CW-1:0]            scan_idx_q;
	logic                     rd_vld_s1;
	logic                     div_start_q;

	logic                     out_valid_q;
	logic [1:0]               out_status_q;
	logic                     out_found_q;
	logic [CW-1:0]            out_count_q;
	logic signed [VW-1:0]     out_min_q;
	logic signed [VW-1:0]     out_max_q;
	logic signed [MW-1:0]     out_mean_q;

	logic                     in_fire;
	logic [VW-1:0]            rdata;
	logic                     scan_hit;
	logic                     scan_miss;
	logic                     is_full;
	logic                     ins;
	logic signed [VW-1:0]     ins_val;
	logic [SUM_W-1:0]         sum_mag;
	logic [DVD_W-1:0]         quotient;
	logic                     div_busy;
	logic                     div_done;
	logic signed [MW-1:0]     quo_mean;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Scan compare and insert decision
	always_comb begin
		scan_hit  = (state_q == S_SCAN) && rd_vld_s1 && (rdata == value_q);
		scan_miss = (state_q == S_SCAN) && !rd_vld_s1 && !scan_hit && (scan_idx_q == count_q);
		is_full   = (count_q == CW'(CAPACITY));
		ins       = (in_fire && (uvss_pkg::cmd_t'(cmd) == uvss_pkg::CMD_ADD) &&
		             (count_q == '0)) ||
		            (scan_miss && (cmd_q == uvss_pkg::CMD_ADD) && !is_full);
		ins_val   = (state_q == S_IDLE) ? value : value_q;
		sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		quo_mean  = MW'(quotient);
	end

	uvss_ram #(
		.WIDTH (VW),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ins),
		.waddr (count_q[AW-1:0]),
		.wdata (ins_val),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	uvss_div #(
		.DIVIDEND_W (DVD_W),
		.DIVISOR_W  (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({sum_mag, {FW{1'b0}}}),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// Command sequencer, set statistics and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= uvss_pkg::CMD_ADD;
			value_q      <= '0;
			count_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			mean_q       <= '0;
			status_q     <= uvss_pkg::ST_OK;
			found_q      <= 1'b0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_found_q  <= 1'b0;
			out_count_q  <= '0;
			out_min_q    <= '0;
			out_max_q    <= '0;
			out_mean_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Update the running statistics on a new entry
			if (ins) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(ins_val);
				if (count_q == '0) begin
					min_q <= ins_val;
					max_q <= ins_val;
				end else begin
					if (ins_val < min_q) min_q <= ins_val;
					if (ins_val > max_q) max_q <= ins_val;
				end
				div_start_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cmd_q      <= uvss_pkg::cmd_t'(cmd);
						value_q    <= value;
						found_q    <= 1'b0;
						scan_idx_q <= '0;
						status_q   <= uvss_pkg::ST_OK;
						unique case (uvss_pkg::cmd_t'(cmd))
							uvss_pkg::CMD_ADD: begin
								state_q <= (count_q == '0) ? S_DIV : S_SCAN;
							end
							uvss_pkg::CMD_FIND: begin
								if (count_q == '0) begin
									status_q <= uvss_pkg::ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							uvss_pkg::CMD_CLEAR: begin
								count_q <= '0;
								min_q   <= '0;
								max_q   <= '0;
								sum_q   <= '0;
								mean_q  <= '0;
								state_q <= S_RESP;
							end
							uvss_pkg::CMD_STATS: begin
								if (count_q == '0) begin
									status_q <= uvss_pkg::ST_EMPTY;
								end
								state_q <= S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN: begin
					priority if (scan_hit) begin
						found_q  <= (cmd_q == uvss_pkg::CMD_FIND);
						status_q <= (cmd_q == uvss_pkg::CMD_ADD) ?
						            uvss_pkg::ST_DUP : uvss_pkg::ST_OK;
						state_q  <= S_RESP;
					end else if (scan_miss) begin
						if (cmd_q == uvss_pkg::CMD_FIND) begin
							state_q <= S_RESP;
						end else if (is_full) begin
							status_q <= uvss_pkg::ST_FULL;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						// Issue the next entry read until the last one is out
						if (scan_idx_q != count_q) begin
							rd_vld_s1  <= 1'b1;
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						mean_q  <= sum_q[SUM_W-1] ? -quo_mean : quo_mean;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					// Load the beat once the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_found_q  <= found_q;
						out_count_q  <= count_q;
						out_min_q    <= min_q;
						out_max_q    <= max_q;
						out_mean_q   <= mean_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign entry_count = out_count_q;
	assign smallest    = out_min_q;
	assign largest     = out_max_q;
	assign mean_fixed  = out_mean_q;

`ifndef NO_ASSERTIONS
	// Count never passes the set size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// Empty set keeps all statistics at zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (min_q == '0 && max_q == '0 && sum_q == '0 && mean_q == '0))
		else $error("statistics nonzero on empty set");

	// Minimum never exceeds maximum
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= max_q)
		else $error("running min above running max");

	// Divider works only while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy || div_done) |-> (state_q == S_DIV))
		else $error("divider active outside mean update");
`endif

endmodule
